// ----- design/mts_pkg.sv -----
// shared types and constants for the markov token sampler
// request and result payloads, operation, status and register codes
// no dependencies
`default_nettype none
package mts_pkg;

	localparam int MAX_STATES_DEF  = 16;
	localparam int MAX_TOKENS_DEF  = 64;
	localparam int COUNT_WIDTH_DEF = 16;
	localparam int RANDOM_W        = 31;

	typedef enum logic [1:0] {
		OP_WR_TRANS = 2'd0,
		OP_WR_EMIT  = 2'd1,
		OP_START    = 2'd2,
		OP_STEP     = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_ZERO_TOTAL = 2'd1,
		ST_IDLE_STEP  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CFG_STATE_COUNT  = 2'd0,
		CFG_TOKEN_COUNT  = 2'd1,
		CFG_LENGTH_LIMIT = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		op_t                 operation;
		logic [3:0]          row_index;
		logic [5:0]          column_index;
		logic [15:0]         count_value;
		logic [RANDOM_W-1:0] random_a;
		logic [RANDOM_W-1:0] random_b;
	} request_t;

	typedef struct packed {
		logic        token_valid;
		logic [5:0]  token_index;
		logic [4:0]  next_state;
		logic [15:0] emitted_length;
		logic        sequence_done;
		status_t     status;
	} result_t;

endpackage
`default_nettype wire

// ----- design/markov_token_sampler.sv -----
// top level of the markov token sampler: control sequencer, count memories, row totals
// depends on mts_pkg, mts_count_mem, mts_divrem, mts_scan
//
// Transition and emission counts sit in two synchronous memories, row totals in
// flip-flops. After reset a clearing pass writes zero to every memory word, one word
// a cycle, over 2**(row bits + widest column bits) addresses (1024 with default
// sizes); no request is taken meanwhile, configuration writes are. One request is
// processed at a time. A table write reads the old count, then updates the count and
// the row total; a start request is handled in the idle state. Unless the walk is
// idle or at its end, a step runs two remainder units side by side, then scans the
// emission row and the transition row one memory word per cycle, a row only if its
// total is not zero, each scan stopping at the chosen column. A result waits in an
// output register and the next request is accepted while it does; a step whose
// result finds that register still full waits for it to be taken.
`default_nettype none
module markov_token_sampler #(
	parameter int MAX_STATES  = mts_pkg::MAX_STATES_DEF,
	parameter int MAX_TOKENS  = mts_pkg::MAX_TOKENS_DEF,
	parameter int COUNT_WIDTH = mts_pkg::COUNT_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              request_valid,
	output logic              request_ready,
	input  mts_pkg::request_t request,
	output logic              result_valid,
	input  logic              result_ready,
	output mts_pkg::result_t  result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data
);

	localparam int ROW_W = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
	localparam int TRC_W = $clog2(MAX_STATES + 1);
	localparam int TKC_W = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;
	localparam int NT_W  = $clog2(MAX_TOKENS + 1);
	localparam int CW    = COUNT_WIDTH;
	localparam int ETW   = CW + TKC_W;
	localparam int TTW   = CW + TRC_W;
	localparam int AW    = (ETW > TTW) ? ETW : TTW;
	localparam int N_W   = (NT_W > TRC_W + 1) ? NT_W : TRC_W + 1;
	localparam int EA_W  = ROW_W + TKC_W;
	localparam int TA_W  = ROW_W + TRC_W;
	localparam int CLR_W = (EA_W > TA_W) ? EA_W : TA_W;
	localparam int RND_W = mts_pkg::RANDOM_W;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_WR_RD,
		S_WR_UPD,
		S_STEP,
		S_DIV,
		S_ESCAN,
		S_TPICK,
		S_TSCAN,
		S_RESULT
	} state_t;

	state_t             state_q;
	logic [CLR_W-1:0]   clr_q;
	mts_pkg::request_t  req_q;
	logic [TRC_W-1:0]   cur_q;
	logic [15:0]        len_q;
	logic               active_q;
	logic               tvalid_q;
	logic [N_W-1:0]     tok_q;
	logic               done_q;
	mts_pkg::status_t   status_q;
	logic               result_valid_q;
	mts_pkg::result_t   result_q;

	logic [4:0]         state_count_q;
	logic [6:0]         token_count_q;
	logic [15:0]        len_limit_q;

	logic [ETW-1:0]     etot_q [MAX_STATES];
	logic [TTW-1:0]     ttot_q [MAX_STATES];

	logic [TRC_W-1:0]   ns;
	logic [NT_W-1:0]    nt;
	logic [ROW_W-1:0]   req_row;
	logic [TKC_W-1:0]   req_ecol;
	logic [TRC_W-1:0]   req_tcol;
	logic [ROW_W-1:0]   cur_row;
	logic [ROW_W-1:0]   tot_idx;
	logic [ETW-1:0]     etot_rd;
	logic [TTW-1:0]     ttot_rd;
	logic [CW-1:0]      cnt_w;
	logic               row_ok;
	logic               wr_ok_t;
	logic               wr_ok_e;
	logic               step_end;

	logic               e_we;
	logic [EA_W-1:0]    e_waddr;
	logic [EA_W-1:0]    e_raddr;
	logic [CW-1:0]      e_wdata;
	logic [CW-1:0]      e_rdata;
	logic               t_we;
	logic [TA_W-1:0]    t_waddr;
	logic [TA_W-1:0]    t_raddr;
	logic [CW-1:0]      t_wdata;
	logic [CW-1:0]      t_rdata;

	logic               div_start;
	logic               div_done_a;
	logic               div_done_b;
	logic               div_done;
	logic [AW-1:0]      rem_a;
	logic [AW-1:0]      rem_b;

	logic               scan_start;
	logic [N_W-1:0]     scan_n;
	logic [AW-1:0]      scan_thr;
	logic [CW-1:0]      scan_rdata;
	logic [N_W-1:0]     scan_col;
	logic               scan_done;
	logic [N_W-1:0]     scan_pick;
	logic               pick_end;

	// effective register values
	assign ns = (32'(state_count_q) < MAX_STATES) ? TRC_W'(state_count_q) : TRC_W'(MAX_STATES);
	assign nt = (32'(token_count_q) < MAX_TOKENS) ? NT_W'(token_count_q) : NT_W'(MAX_TOKENS);

	assign req_row  = ROW_W'(req_q.row_index);
	assign req_ecol = TKC_W'(req_q.column_index);
	assign req_tcol = TRC_W'(req_q.column_index);
	assign cur_row  = cur_q[ROW_W-1:0];
	assign cnt_w    = CW'(req_q.count_value);

	assign tot_idx = (state_q == S_WR_UPD) ? req_row : cur_row;
	assign etot_rd = etot_q[tot_idx];
	assign ttot_rd = ttot_q[tot_idx];

	assign row_ok  = 32'(req_q.row_index) < 32'(ns);
	assign wr_ok_t = (req_q.operation == mts_pkg::OP_WR_TRANS) && row_ok
		&& (32'(req_q.column_index) <= 32'(ns));
	assign wr_ok_e = (req_q.operation == mts_pkg::OP_WR_EMIT) && row_ok
		&& (32'(req_q.column_index) < 32'(nt));

	assign step_end = (32'(cur_q) >= 32'(ns)) || (len_q >= len_limit_q);

	// memory ports
	assign e_raddr = (state_q == S_WR_RD) ? {req_row, req_ecol} : {cur_row, scan_col[TKC_W-1:0]};
	assign t_raddr = (state_q == S_WR_RD) ? {req_row, req_tcol} : {cur_row, scan_col[TRC_W-1:0]};
	assign e_we    = (state_q == S_CLEAR) || ((state_q == S_WR_UPD) && wr_ok_e);
	assign t_we    = (state_q == S_CLEAR) || ((state_q == S_WR_UPD) && wr_ok_t);
	assign e_waddr = (state_q == S_CLEAR) ? clr_q[EA_W-1:0] : {req_row, req_ecol};
	assign t_waddr = (state_q == S_CLEAR) ? clr_q[TA_W-1:0] : {req_row, req_tcol};
	assign e_wdata = (state_q == S_CLEAR) ? '0 : cnt_w;
	assign t_wdata = (state_q == S_CLEAR) ? '0 : cnt_w;

	// remainder units and scan control
	assign div_start  = (state_q == S_STEP) && active_q && !step_end;
	assign div_done   = div_done_a && div_done_b;
	assign scan_start = ((state_q == S_DIV) && div_done && (etot_rd != '0))
		|| ((state_q == S_TPICK) && (ttot_rd != '0));
	assign scan_n     = (state_q == S_DIV) ? N_W'(nt) : (N_W'(ns) + N_W'(1));
	assign scan_thr   = (state_q == S_DIV) ? (rem_a + AW'(1)) : (rem_b + AW'(1));
	assign scan_rdata = (state_q == S_TSCAN) ? t_rdata : e_rdata;
	assign pick_end   = (32'(scan_pick) >= 32'(ns)) || (len_q >= len_limit_q);

	mts_count_mem #(
		.ADDR_W(EA_W),
		.DATA_W(CW)
	) u_emit_mem (
		.clk  (clk),
		.we   (e_we),
		.waddr(e_waddr),
		.wdata(e_wdata),
		.raddr(e_raddr),
		.rdata(e_rdata)
	);

	mts_count_mem #(
		.ADDR_W(TA_W),
		.DATA_W(CW)
	) u_trans_mem (
		.clk  (clk),
		.we   (t_we),
		.waddr(t_waddr),
		.wdata(t_wdata),
		.raddr(t_raddr),
		.rdata(t_rdata)
	);

	mts_divrem #(
		.NUM_W(RND_W),
		.DEN_W(AW)
	) u_div_emit (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.numer (req_q.random_a),
		.denom (AW'(etot_rd)),
		.done  (div_done_a),
		.rem   (rem_a)
	);

	mts_divrem #(
		.NUM_W(RND_W),
		.DEN_W(AW)
	) u_div_trans (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.numer (req_q.random_b),
		.denom (AW'(ttot_rd)),
		.done  (div_done_b),
		.rem   (rem_b)
	);

	mts_scan #(
		.N_W(N_W),
		.AW (AW),
		.CW (CW)
	) u_scan (
		.clk   (clk),
		.arst_n(arst_n),
		.start (scan_start),
		.n     (scan_n),
		.thr   (scan_thr),
		.rdata (scan_rdata),
		.rd_col(scan_col),
		.done  (scan_done),
		.pick  (scan_pick)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_count_q <= 5'd1;
			token_count_q <= 7'd1;
			len_limit_q   <= 16'hFFFF;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mts_pkg::CFG_STATE_COUNT: begin
					state_count_q <= cfg_data[4:0];
				end
				mts_pkg::CFG_TOKEN_COUNT: begin
					token_count_q <= cfg_data[6:0];
				end
				mts_pkg::CFG_LENGTH_LIMIT: begin
					len_limit_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// row totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_STATES; i++) begin
				etot_q[i] <= '0;
				ttot_q[i] <= '0;
			end
		end else if (state_q == S_WR_UPD) begin
			if (wr_ok_e) begin
				etot_q[tot_idx] <= etot_rd - ETW'(e_rdata) + ETW'(cnt_w);
			end
			if (wr_ok_t) begin
				ttot_q[tot_idx] <= ttot_rd - TTW'(t_rdata) + TTW'(cnt_w);
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			clr_q          <= '0;
			req_q          <= '0;
			cur_q          <= '0;
			len_q          <= '0;
			active_q       <= 1'b0;
			tvalid_q       <= 1'b0;
			tok_q          <= '0;
			done_q         <= 1'b0;
			status_q       <= mts_pkg::ST_OK;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + CLR_W'(1);
					if (&clr_q) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (request_valid) begin
						req_q <= request;
						case (request.operation)
							mts_pkg::OP_START: begin
								cur_q    <= '0;
								len_q    <= '0;
								active_q <= 1'b1;
							end
							mts_pkg::OP_STEP: begin
								state_q <= S_STEP;
							end
							default: begin
								state_q <= S_WR_RD;
							end
						endcase
					end
				end
				S_WR_RD: begin
					state_q <= S_WR_UPD;
				end
				S_WR_UPD: begin
					state_q <= S_IDLE;
				end
				S_STEP: begin
					tvalid_q <= 1'b0;
					tok_q    <= '0;
					done_q   <= 1'b0;
					status_q <= mts_pkg::ST_OK;
					if (!active_q) begin
						status_q <= mts_pkg::ST_IDLE_STEP;
						state_q  <= S_RESULT;
					end else if (step_end) begin
						done_q   <= 1'b1;
						active_q <= 1'b0;
						state_q  <= S_RESULT;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= (etot_rd != '0) ? S_ESCAN : S_TPICK;
					end
				end
				S_ESCAN: begin
					if (scan_done) begin
						tvalid_q <= 1'b1;
						tok_q    <= scan_pick;
						len_q    <= len_q + 16'd1;
						state_q  <= S_TPICK;
					end
				end
				S_TPICK: begin
					if (ttot_rd == '0) begin
						status_q <= mts_pkg::ST_ZERO_TOTAL;
						done_q   <= 1'b1;
						active_q <= 1'b0;
						state_q  <= S_RESULT;
					end else begin
						state_q <= S_TSCAN;
					end
				end
				S_TSCAN: begin
					if (scan_done) begin
						cur_q   <= TRC_W'(scan_pick);
						state_q <= S_RESULT;
						if (pick_end) begin
							done_q   <= 1'b1;
							active_q <= 1'b0;
						end
					end
				end
				S_RESULT: begin
					if (!result_valid_q || result_ready) begin
						result_valid_q          <= 1'b1;
						result_q.token_valid    <= tvalid_q;
						result_q.token_index    <= 6'(tok_q);
						result_q.next_state     <= 5'(cur_q);
						result_q.emitted_length <= len_q;
						result_q.sequence_done  <= done_q;
						result_q.status         <= status_q;
						state_q                 <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign request_ready = (state_q == S_IDLE);
	assign cfg_ready     = 1'b1;
	assign result_valid  = result_valid_q;
	assign result        = result_q;

	a_idle_step_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status == mts_pkg::ST_IDLE_STEP
		|-> !result.token_valid && !result.sequence_done)
		else $error("idle step reported a token or an end");

	a_result_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == S_RESULT))
		else $error("result raised outside result state");

	a_tscan_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_TSCAN |-> ttot_rd != '0)
		else $error("transition scan on empty row");

	a_len_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ESCAN && scan_done |=> len_q == $past(len_q) + 16'd1)
		else $error("length not advanced on emitted token");

endmodule
`default_nettype wire

// ----- design/mts_count_mem.sv -----
// single-port-write, single-port-read count memory with registered read data
// no dependencies
`default_nettype none
module mts_count_mem #(
	parameter int ADDR_W = 10,
	parameter int DATA_W = 16
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [2**ADDR_W];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ----- design/mts_divrem.sv -----
// iterative restoring remainder unit, one numerator bit per cycle
// no dependencies
`default_nettype none
module mts_divrem #(
	parameter int NUM_W = 31,
	parameter int DEN_W = 22
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] numer,
	input  logic [DEN_W-1:0] denom,
	output logic             done,
	output logic [DEN_W-1:0] rem
);

	localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W:0]   shifted;
	logic [DEN_W:0]   den_x;
	logic [DEN_W:0]   diff;
	logic [DEN_W-1:0] rem_nx;

	assign shifted = {rem_q, num_q[NUM_W-1]};
	assign den_x   = {1'b0, den_q};
	assign diff    = shifted - den_x;
	assign rem_nx  = (shifted >= den_x) ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			num_q  <= '0;
			den_q  <= '0;
			rem_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				num_q  <= numer;
				den_q  <= denom;
				rem_q  <= '0;
			end else if (busy_q) begin
				rem_q <= rem_nx;
				num_q <= num_q << 1;
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && den_q != '0 |-> rem_q < den_q)
		else $error("remainder not below divisor");

endmodule
`default_nettype wire

// ----- design/mts_scan.sv -----
// cumulative count scan over one table row read from a memory
// issues one column address per cycle and compares the running sum in the cycle after
`default_nettype none
module mts_scan #(
	parameter int N_W = 7,
	parameter int AW  = 22,
	parameter int CW  = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [N_W-1:0] n,
	input  logic [AW-1:0]  thr,
	input  logic [CW-1:0]  rdata,
	output logic [N_W-1:0] rd_col,
	output logic           done,
	output logic [N_W-1:0] pick
);

	logic           busy_q;
	logic           done_q;
	logic           vld_s1;
	logic [N_W-1:0] rd_col_q;
	logic [N_W-1:0] col_s1;
	logic [N_W-1:0] n_q;
	logic [N_W-1:0] pick_q;
	logic [AW-1:0]  acc_q;
	logic [AW-1:0]  thr_q;
	logic [AW-1:0]  acc_nx;
	logic           issue;
	logic           hit;
	logic           last;

	assign issue  = busy_q && (rd_col_q < n_q);
	assign acc_nx = acc_q + AW'(rdata);
	assign hit    = acc_nx >= thr_q;
	assign last   = col_s1 == (n_q - N_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			done_q   <= 1'b0;
			vld_s1   <= 1'b0;
			rd_col_q <= '0;
			col_s1   <= '0;
			n_q      <= '0;
			pick_q   <= '0;
			acc_q    <= '0;
			thr_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q   <= (n != '0);
				vld_s1   <= 1'b0;
				rd_col_q <= '0;
				acc_q    <= '0;
				n_q      <= n;
				thr_q    <= thr;
				if (n == '0) begin
					done_q <= 1'b1;
					pick_q <= '0;
				end
			end else if (busy_q) begin
				vld_s1 <= issue;
				col_s1 <= rd_col_q;
				if (issue) begin
					rd_col_q <= rd_col_q + N_W'(1);
				end
				if (vld_s1) begin
					if (hit || last) begin
						busy_q <= 1'b0;
						vld_s1 <= 1'b0;
						done_q <= 1'b1;
						pick_q <= col_s1;
					end else begin
						acc_q <= acc_nx;
					end
				end
			end
		end
	end

	assign rd_col = rd_col_q;
	assign done   = done_q;
	assign pick   = pick_q;

	a_pick_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (pick_q < n_q) || (n_q == '0))
		else $error("scan pick outside row");

endmodule
`default_nettype wire

// ----- tb/mts_result_checker.sv -----
`timescale 1ns / 1ps
// result checker for the markov token sampler: mirrors the count tables, row totals and
// walk, predicts each step result and compares it with what the block returns
// depends on mts_pkg
module mts_result_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              request_valid,
	input  logic              request_ready,
	input  mts_pkg::request_t request,
	input  logic              result_valid,
	input  logic              result_ready,
	input  mts_pkg::result_t  result,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	output int                fail_count,
	output int                pending
);
	localparam int N_STATES = mts_pkg::MAX_STATES_DEF;
	localparam int N_TOKENS = mts_pkg::MAX_TOKENS_DEF;

	int unsigned trans_cnt [N_STATES][N_STATES+1];
	int unsigned emit_cnt [N_STATES][N_TOKENS];
	int unsigned trans_tot [N_STATES];
	int unsigned emit_tot [N_STATES];
	int unsigned n_state_reg;
	int unsigned n_token_reg;
	int unsigned len_limit;
	int unsigned walk_state;
	int unsigned walk_len;
	bit          walking;
	mts_pkg::result_t pending_samples [$];
	mts_pkg::result_t due;
	int          mismatches;
	int          results_seen;

	// first column whose running count reaches (rnd mod total) + 1
	function automatic int unsigned choose_column(input bit from_emission,
			input int unsigned row, input int unsigned n, input int unsigned total,
			input int unsigned rnd);
		int unsigned threshold;
		int unsigned acc;
		threshold = rnd % total + 1;
		acc = 0;
		for (int unsigned i = 0; i < n; i++) begin
			acc += from_emission ? emit_cnt[row][i] : trans_cnt[row][i];
			if (acc >= threshold)
				return i;
		end
		return (n != 0) ? n - 1 : 0;
	endfunction

	task automatic report(input string msg);
		$display("%0t check: %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got)
			report($sformatf("result %0d %s: expected %0d, got %0d",
				results_seen, name, want, got));
	endtask

	task automatic sample_step(input mts_pkg::request_t req);
		int unsigned ns;
		int unsigned nt;
		int unsigned s;
		mts_pkg::result_t forecast;
		ns = (n_state_reg < N_STATES) ? n_state_reg : N_STATES;
		nt = (n_token_reg < N_TOKENS) ? n_token_reg : N_TOKENS;
		case (req.operation)
		mts_pkg::OP_WR_TRANS: begin
			if (req.row_index < ns && req.column_index <= ns) begin
				trans_tot[req.row_index] = trans_tot[req.row_index]
					- trans_cnt[req.row_index][req.column_index] + req.count_value;
				trans_cnt[req.row_index][req.column_index] = req.count_value;
			end
		end
		mts_pkg::OP_WR_EMIT: begin
			if (req.row_index < ns && req.column_index < nt) begin
				emit_tot[req.row_index] = emit_tot[req.row_index]
					- emit_cnt[req.row_index][req.column_index] + req.count_value;
				emit_cnt[req.row_index][req.column_index] = req.count_value;
			end
		end
		mts_pkg::OP_START: begin
			walk_state = 0;
			walk_len = 0;
			walking = 1'b1;
		end
		default: begin
			forecast = '0;
			forecast.status = mts_pkg::ST_OK;
			if (!walking) begin
				forecast.status = mts_pkg::ST_IDLE_STEP;
			end else if (walk_state >= ns || walk_len >= len_limit) begin
				forecast.sequence_done = 1'b1;
				walking = 1'b0;
			end else begin
				s = walk_state;
				if (emit_tot[s] > 0) begin
					forecast.token_index = 6'(choose_column(1'b1, s, nt, emit_tot[s],
						req.random_a));
					forecast.token_valid = 1'b1;
					walk_len = (walk_len + 1) & 32'hFFFF;
				end
				if (trans_tot[s] == 0) begin
					forecast.status = mts_pkg::ST_ZERO_TOTAL;
					forecast.sequence_done = 1'b1;
					walking = 1'b0;
				end else begin
					walk_state = choose_column(1'b0, s, ns + 1, trans_tot[s], req.random_b);
					if (walk_state >= ns || walk_len >= len_limit) begin
						forecast.sequence_done = 1'b1;
						walking = 1'b0;
					end
				end
			end
			forecast.next_state = walk_state[4:0];
			forecast.emitted_length = walk_len[15:0];
			pending_samples.push_back(forecast);
		end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < N_STATES; r++) begin
				for (int c = 0; c <= N_STATES; c++)
					trans_cnt[r][c] = 0;
				for (int c = 0; c < N_TOKENS; c++)
					emit_cnt[r][c] = 0;
				trans_tot[r] = 0;
				emit_tot[r] = 0;
			end
			n_state_reg = 1;
			n_token_reg = 1;
			len_limit = 65535;
			walk_state = 0;
			walk_len = 0;
			walking = 1'b0;
			pending_samples.delete();
			mismatches = 0;
			results_seen = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (result_valid && result_ready) begin
				if (pending_samples.size() == 0) begin
					report($sformatf("result %0d came with no step request waiting",
						results_seen));
				end else begin
					due = pending_samples.pop_front();
					check_field("token_valid", due.token_valid, result.token_valid);
					check_field("token_index", due.token_index, result.token_index);
					check_field("next_state", due.next_state, result.next_state);
					check_field("emitted_length", due.emitted_length, result.emitted_length);
					check_field("sequence_done", due.sequence_done, result.sequence_done);
					check_field("status", due.status, result.status);
				end
				results_seen++;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				mts_pkg::CFG_STATE_COUNT:  n_state_reg = cfg_data[4:0];
				mts_pkg::CFG_TOKEN_COUNT:  n_token_reg = cfg_data[6:0];
				mts_pkg::CFG_LENGTH_LIMIT: len_limit = cfg_data;
				default: ;
				endcase
			end
			if (request_valid && request_ready)
				sample_step(request);
			pending <= pending_samples.size();
			fail_count <= mismatches;
		end
	end

endmodule

// ----- tb/tb_markov_token_sampler.sv -----
`timescale 1ns / 1ps
// testbench top for the markov token sampler: clock, reset, request and register
// stimulus and the verdict; results are predicted and checked by mts_result_checker
// depends on mts_pkg, markov_token_sampler, mts_result_checker
module tb_markov_token_sampler;

	localparam int TOTAL_ITEMS   = 1700;
	localparam int SETTLE_CYCLES = 160;
	localparam int TIMEOUT_NS    = 20_000_000;
	localparam logic [1:0] CFG_SPARE = 2'd3;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              request_valid = 1'b0;
	logic              request_ready;
	mts_pkg::request_t request = '0;
	logic              result_valid;
	logic              result_ready = 1'b0;
	mts_pkg::result_t  result;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [1:0]        cfg_index = '0;
	logic [15:0]       cfg_data = '0;
	int                fail_count;
	int                pending;
	int                snd_idle = 33;
	int                rcv_idle = 52;
	int                sent = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	markov_token_sampler dut (
		.clk(clk),
		.arst_n(arst_n),
		.request_valid(request_valid),
		.request_ready(request_ready),
		.request(request),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	mts_result_checker watcher (
		.clk(clk),
		.arst_n(arst_n),
		.request_valid(request_valid),
		.request_ready(request_ready),
		.request(request),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.pending(pending)
	);

	always @(posedge clk) begin
		result_ready <= ($urandom_range(99) >= rcv_idle);
	end

	function automatic logic [30:0] pick_random();
		case ($urandom_range(9))
		0: return '0;
		1: return '1;
		default: return 31'($urandom());
		endcase
	endfunction

	function automatic logic [15:0] pick_count();
		case ($urandom_range(9))
		0: return '0;
		1: return '1;
		2, 3, 4: return 16'($urandom_range(20, 1));
		default: return 16'($urandom());
		endcase
	endfunction

	function automatic mts_pkg::request_t make_req(input mts_pkg::op_t op,
			input logic [3:0] row, input logic [5:0] col, input logic [15:0] cnt,
			input logic [30:0] ra, input logic [30:0] rb);
		mts_pkg::request_t r;
		r.operation = op;
		r.row_index = row;
		r.column_index = col;
		r.count_value = cnt;
		r.random_a = ra;
		r.random_b = rb;
		return r;
	endfunction

	task automatic send(input mts_pkg::request_t r);
		if ($urandom_range(99) < snd_idle) begin
			request_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < snd_idle);
		end
		request <= r;
		request_valid <= 1'b1;
		do @(posedge clk); while (!request_ready);
		sent++;
		if (sent < TOTAL_ITEMS / 3) begin
			snd_idle = 33;
			rcv_idle <= 52;
		end else if (sent < 2 * TOTAL_ITEMS / 3) begin
			snd_idle = 52;
			rcv_idle <= 33;
		end else begin
			snd_idle = 0;
			rcv_idle <= 0;
		end
	endtask

	// hold off requests until every step result is back and the block is quiet
	task automatic drain();
		request_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_config(input int sc, input int tc, input int ll);
		write_reg(mts_pkg::CFG_STATE_COUNT, 16'(sc));
		write_reg(mts_pkg::CFG_TOKEN_COUNT, 16'(tc));
		write_reg(mts_pkg::CFG_LENGTH_LIMIT, 16'(ll));
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(input int sc, input int tc, input int ll, input int n_items);
		int ns;
		int nt;
		int first;
		int kind;
		mts_pkg::op_t wop;
		logic [5:0] wcol;
		drain();
		set_config(sc, tc, ll);
		ns = (sc < mts_pkg::MAX_STATES_DEF) ? sc : mts_pkg::MAX_STATES_DEF;
		nt = (tc < mts_pkg::MAX_TOKENS_DEF) ? tc : mts_pkg::MAX_TOKENS_DEF;
		first = sent;
		// sparse table load so that walks get somewhere
		for (int r = 0; r < ns; r++) begin
			if ($urandom_range(3) != 0) begin
				repeat ($urandom_range(3, 1))
					send(make_req(mts_pkg::OP_WR_TRANS, 4'(r), 6'($urandom_range(ns)),
						pick_count(), pick_random(), pick_random()));
			end
			if (nt > 0 && $urandom_range(3) != 0) begin
				repeat ($urandom_range(3, 1))
					send(make_req(mts_pkg::OP_WR_EMIT, 4'(r), 6'($urandom_range(nt - 1)),
						pick_count(), pick_random(), pick_random()));
			end
		end
		while (sent - first < n_items) begin
			kind = $urandom_range(99);
			if (kind < 12 && ns > 0) begin
				wop = ($urandom_range(1) != 0) ? mts_pkg::OP_WR_EMIT : mts_pkg::OP_WR_TRANS;
				if (wop == mts_pkg::OP_WR_TRANS)
					wcol = 6'($urandom_range(ns));
				else
					wcol = 6'((nt > 0) ? $urandom_range(nt - 1) : $urandom());
				send(make_req(wop, 4'($urandom_range(ns - 1)), wcol, pick_count(),
					pick_random(), pick_random()));
			end else if (kind < 20) begin
				send(make_req(mts_pkg::op_t'(2'($urandom_range(3))), 4'($urandom()),
					6'($urandom()), 16'($urandom()), 31'($urandom()), 31'($urandom())));
			end else begin
				send(make_req(mts_pkg::OP_START, 4'($urandom()), 6'($urandom()),
					pick_count(), pick_random(), pick_random()));
				repeat ($urandom_range(8, 1))
					send(make_req(mts_pkg::OP_STEP, 4'($urandom()), 6'($urandom()),
						pick_count(), pick_random(), pick_random()));
			end
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		write_reg(CFG_SPARE, 16'hFFFF);
		set_config(4, 8, 65535);

		// step while idle, then a walk over empty tables
		send(make_req(mts_pkg::OP_STEP, 4'd15, 6'd63, 16'hFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF));
		send(make_req(mts_pkg::OP_START, 4'd0, 6'd0, 16'd0, 31'd0, 31'd0));
		send(make_req(mts_pkg::OP_STEP, 4'd0, 6'd0, 16'd0, 31'd0, 31'd0));
		// table writes, in range and out of range
		send(make_req(mts_pkg::OP_WR_TRANS, 4'd0, 6'd0, 16'hFFFF, 31'd0, 31'd0));
		send(make_req(mts_pkg::OP_WR_TRANS, 4'd0, 6'd4, 16'd1, 31'd0, 31'd0));
		send(make_req(mts_pkg::OP_WR_TRANS, 4'd15, 6'd63, 16'd5, 31'd0, 31'd0));
		send(make_req(mts_pkg::OP_WR_TRANS, 4'd0, 6'd5, 16'd7, 31'd0, 31'd0));
		send(make_req(mts_pkg::OP_WR_EMIT, 4'd0, 6'd7, 16'hFFFF, 31'd0, 31'd0));
		send(make_req(mts_pkg::OP_WR_EMIT, 4'd0, 6'd0, 16'd0, 31'd0, 31'd0));
		send(make_req(mts_pkg::OP_WR_EMIT, 4'd3, 6'd8, 16'd9, 31'd0, 31'd0));
		send(make_req(mts_pkg::OP_WR_EMIT, 4'd1, 6'd63, 16'd1, 31'd0, 31'd0));
		// walk with extreme random values, ends on the terminal state
		send(make_req(mts_pkg::OP_START, 4'd0, 6'd0, 16'd0, 31'd0, 31'd0));
		send(make_req(mts_pkg::OP_STEP, 4'd0, 6'd0, 16'd0, 31'd0, 31'd0));
		send(make_req(mts_pkg::OP_STEP, 4'd0, 6'd0, 16'd0, 31'h7FFFFFFF, 31'h7FFFFFFF));
		send(make_req(mts_pkg::OP_STEP, 4'd0, 6'd0, 16'd0, 31'd0, 31'd0));
		// count rewritten lower, only the terminal column left
		send(make_req(mts_pkg::OP_WR_TRANS, 4'd0, 6'd0, 16'd0, 31'd0, 31'd0));
		send(make_req(mts_pkg::OP_START, 4'd0, 6'd0, 16'd0, 31'd0, 31'd0));
		send(make_req(mts_pkg::OP_STEP, 4'd0, 6'd0, 16'd0, 31'h7FFFFFFF, 31'd0));
		send(make_req(mts_pkg::OP_WR_EMIT, 4'd0, 6'd0, 16'hFFFF, 31'd0, 31'd0));
		send(make_req(mts_pkg::OP_START, 4'd0, 6'd0, 16'd0, 31'd0, 31'd0));
		send(make_req(mts_pkg::OP_STEP, 4'd0, 6'd0, 16'd0, 31'd0, 31'd0));

		run_phase(16, 64, 65535, 300);
		run_phase(1, 1, 1, 150);
		run_phase($urandom_range(8, 2), $urandom_range(16, 2), $urandom_range(10, 2), 300);
		run_phase(31, 127, 65535, 250);
		run_phase(5, 3, 3, 200);
		run_phase(3, 0, 5, 100);
		run_phase(0, 40, 0, 50);
		run_phase($urandom_range(16, 1), $urandom_range(64, 1), $urandom_range(20, 1), 350);
		drain();

		if (fail_count == 0 && pending == 0)
			$display("markov_token_sampler: match");
		else
			$display("markov_token_sampler: mismatch");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("markov_token_sampler: mismatch");
		$finish;
	end

endmodule
